@@ src/mst_pkg.sv @@
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants for the moving sphere impact time pipeline.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int FIELD_W   = 63;
	localparam int RAD_W     = 20;
	localparam int SPEED_W   = 32;
	localparam int TIME_W    = 32;
	localparam int TIME_FRAC = 16;

	typedef enum logic [1:0] {
		CLS_NONE    = 2'd0,
		CLS_OVERLAP = 2'd1,
		CLS_HIT     = 2'd2
	} contact_t;

	typedef struct packed {
		logic [FIELD_W-1:0] center_a;
		logic [FIELD_W-1:0] center_b;
		logic [RAD_W-1:0]   radius_a;
		logic [RAD_W-1:0]   radius_b;
		logic [FIELD_W-1:0] velocity_a;
		logic [FIELD_W-1:0] velocity_b;
	} req_t;

	typedef struct packed {
		contact_t            contact_class;
		logic [TIME_W-1:0]   impact_time;
	} rsp_t;

	// valid bit and collision class travelling down the pipeline
	typedef struct packed {
		logic     valid;
		contact_t cls;
	} tag_t;

endpackage

@@ src/mst_front.sv @@
// ----------------------------------------------------------------------------
// mst_front
// Relative position/velocity, dot products, c = s.s - R*R and early
// classification (overlap, too slow, separating). Four register stages.
// ----------------------------------------------------------------------------
module mst_front #(
	parameter int CW = 21,
	parameter int FB = 8,
	parameter int MW = 47
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_i,
	input  mst_pkg::req_t                 req_i,
	input  logic [mst_pkg::SPEED_W-1:0]   msq_i,
	output mst_pkg::tag_t                 tag_o,
	output logic [MW-1:0]                 a_o,
	output logic [MW-1:0]                 bmag_o,
	output logic [MW-1:0]                 c_o
);
	import mst_pkg::*;

	localparam int SW   = CW + 1;
	localparam int PW   = 2 * SW;
	localparam int DW   = PW + 2;
	localparam int RSW  = RAD_W + 1;
	localparam int RRW  = 2 * RSW;
	localparam int CMPA = DW + TIME_FRAC;
	localparam int CMPB = SPEED_W + 2 * FB;
	localparam int CMPW = (CMPA > CMPB) ? CMPA : CMPB;

	logic              valid_s1, valid_s2, valid_s3;
	logic signed [SW-1:0] s_s1 [3];
	logic signed [SW-1:0] v_s1 [3];
	logic [RSW-1:0]    rsum_s1;

	logic signed [PW-1:0] ss_s2 [3];
	logic signed [PW-1:0] vv_s2 [3];
	logic signed [PW-1:0] vs_s2 [3];
	logic [RRW-1:0]    rr_s2;

	logic signed [DW-1:0] vv_s3, vs_s3;
	logic signed [MW-1:0] c_s3;

	tag_t              tag_s4;
	logic [MW-1:0]     a_s4, bmag_s4, c_s4;

	logic [CMPW-1:0]   speed_lhs, speed_rhs;
	logic              slow, sep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			tag_s4   <= '0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			tag_s4.valid <= valid_s3;
			if (c_s3[MW-1])
				tag_s4.cls <= CLS_OVERLAP;
			else if (slow || sep)
				tag_s4.cls <= CLS_NONE;
			else
				tag_s4.cls <= CLS_HIT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= {req_i.center_b[i*CW+CW-1], req_i.center_b[i*CW +: CW]}
					- {req_i.center_a[i*CW+CW-1], req_i.center_a[i*CW +: CW]};
				v_s1[i] <= {req_i.velocity_b[i*CW+CW-1], req_i.velocity_b[i*CW +: CW]}
					- {req_i.velocity_a[i*CW+CW-1], req_i.velocity_a[i*CW +: CW]};
				ss_s2[i] <= s_s1[i] * s_s1[i];
				vv_s2[i] <= v_s1[i] * v_s1[i];
				vs_s2[i] <= v_s1[i] * s_s1[i];
			end
			rsum_s1 <= {1'b0, req_i.radius_a} + {1'b0, req_i.radius_b};
			rr_s2   <= RRW'(rsum_s1) * RRW'(rsum_s1);

			vv_s3 <= DW'(vv_s2[0]) + DW'(vv_s2[1]) + DW'(vv_s2[2]);
			vs_s3 <= DW'(vs_s2[0]) + DW'(vs_s2[1]) + DW'(vs_s2[2]);
			c_s3  <= MW'(ss_s2[0]) + MW'(ss_s2[1]) + MW'(ss_s2[2])
				- $signed({{(MW-RRW){1'b0}}, rr_s2});

			a_s4    <= MW'($unsigned(vv_s3));
			bmag_s4 <= MW'(-vs_s3);
			c_s4    <= $unsigned(c_s3);
		end
	end

	// exact compare of a (2*FB frac) against min_speed_sq (16 frac)
	assign speed_lhs = CMPW'($unsigned(vv_s3)) << TIME_FRAC;
	assign speed_rhs = CMPW'(msq_i) << (2 * FB);
	assign slow      = speed_lhs < speed_rhs;
	assign sep       = !vs_s3[DW-1];

	assign tag_o  = tag_s4;
	assign a_o    = a_s4;
	assign bmag_o = bmag_s4;
	assign c_o    = c_s4;

endmodule

@@ src/mst_disc.sv @@
// ----------------------------------------------------------------------------
// mst_disc
// Discriminant d = b*b - a*c. Wide products are split in halves, summed in
// the next stage, then compared and subtracted. Three register stages.
// ----------------------------------------------------------------------------
module mst_disc #(
	parameter int MW = 47
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mst_pkg::tag_t      tag_i,
	input  logic [MW-1:0]      a_i,
	input  logic [MW-1:0]      bmag_i,
	input  logic [MW-1:0]      c_i,
	output mst_pkg::tag_t      tag_o,
	output logic [2*MW-1:0]    d_o,
	output logic [MW-1:0]      a_o,
	output logic [MW-1:0]      bmag_o
);
	import mst_pkg::*;

	localparam int H   = (MW + 1) / 2;
	localparam int HI  = MW - H;
	localparam int DW2 = 2 * MW;

	tag_t              tag_s5, tag_s6, tag_s7;
	logic [MW-1:0]     a_s5, a_s6, a_s7, bmag_s5, bmag_s6, bmag_s7;
	logic [2*H-1:0]    bll_s5, all_s5;
	logic [H+HI-1:0]   blh_s5, alh_s5, ahl_s5;
	logic [2*HI-1:0]   bhh_s5, ahh_s5;
	logic [DW2-1:0]    b2_s6, ac_s6, d_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else if (en) begin
			tag_s5 <= tag_i;
			tag_s6 <= tag_s5;
			tag_s7.valid <= tag_s6.valid;
			if (tag_s6.cls == CLS_HIT && ac_s6 > b2_s6)
				tag_s7.cls <= CLS_NONE;
			else
				tag_s7.cls <= tag_s6.cls;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bll_s5 <= (2*H)'(bmag_i[H-1:0]) * (2*H)'(bmag_i[H-1:0]);
			blh_s5 <= (H+HI)'(bmag_i[H-1:0]) * (H+HI)'(bmag_i[MW-1:H]);
			bhh_s5 <= (2*HI)'(bmag_i[MW-1:H]) * (2*HI)'(bmag_i[MW-1:H]);
			all_s5 <= (2*H)'(a_i[H-1:0]) * (2*H)'(c_i[H-1:0]);
			alh_s5 <= (H+HI)'(a_i[H-1:0]) * (H+HI)'(c_i[MW-1:H]);
			ahl_s5 <= (H+HI)'(a_i[MW-1:H]) * (H+HI)'(c_i[H-1:0]);
			ahh_s5 <= (2*HI)'(a_i[MW-1:H]) * (2*HI)'(c_i[MW-1:H]);
			a_s5    <= a_i;
			bmag_s5 <= bmag_i;

			b2_s6 <= DW2'(bll_s5) + (DW2'(blh_s5) << (H + 1)) + (DW2'(bhh_s5) << (2 * H));
			ac_s6 <= DW2'(all_s5) + (DW2'(alh_s5) << H) + (DW2'(ahl_s5) << H)
				+ (DW2'(ahh_s5) << (2 * H));
			a_s6    <= a_s5;
			bmag_s6 <= bmag_s5;

			d_s7    <= b2_s6 - ac_s6;
			a_s7    <= a_s6;
			bmag_s7 <= bmag_s6;
		end
	end

	assign tag_o  = tag_s7;
	assign d_o    = d_s7;
	assign a_o    = a_s7;
	assign bmag_o = bmag_s7;

endmodule

@@ src/mst_sqrt.sv @@
// ----------------------------------------------------------------------------
// mst_sqrt
// Floored integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module mst_sqrt #(
	parameter int MW = 47
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mst_pkg::tag_t      tag_i,
	input  logic [2*MW-1:0]    d_i,
	input  logic [MW-1:0]      a_i,
	input  logic [MW-1:0]      bmag_i,
	output mst_pkg::tag_t      tag_o,
	output logic [MW-1:0]      root_o,
	output logic [MW-1:0]      a_o,
	output logic [MW-1:0]      bmag_o
);
	import mst_pkg::*;

	localparam int DW2 = 2 * MW;

	tag_t           tag_s  [1:MW];
	logic [DW2-1:0] rem_s  [1:MW];
	logic [MW-1:0]  root_s [1:MW];
	logic [MW-1:0]  a_s    [1:MW];
	logic [MW-1:0]  bmag_s [1:MW];

	for (genvar k = 1; k <= MW; k++) begin : g_stage
		localparam int B = MW - k;
		tag_t           tag_p;
		logic [DW2-1:0] rem_p, trial;
		logic [MW-1:0]  root_p, a_p, bmag_p;

		if (k == 1) begin : g_first
			assign tag_p  = tag_i;
			assign rem_p  = d_i;
			assign root_p = '0;
			assign a_p    = a_i;
			assign bmag_p = bmag_i;
		end else begin : g_next
			assign tag_p  = tag_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign a_p    = a_s[k-1];
			assign bmag_p = bmag_s[k-1];
		end

		// (2*root + 2^B) * 2^B, root holds only bits above B
		assign trial = (DW2'(root_p) << (B + 1)) | (DW2'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				tag_s[k] <= '0;
			else if (en)
				tag_s[k] <= tag_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (trial <= rem_p) begin
					rem_s[k]  <= rem_p - trial;
					root_s[k] <= root_p | (MW'(1) << B);
				end else begin
					rem_s[k]  <= rem_p;
					root_s[k] <= root_p;
				end
				a_s[k]    <= a_p;
				bmag_s[k] <= bmag_p;
			end
		end
	end

	assign tag_o  = tag_s[MW];
	assign root_o = root_s[MW];
	assign a_o    = a_s[MW];
	assign bmag_o = bmag_s[MW];

endmodule

@@ src/mst_div.sv @@
// ----------------------------------------------------------------------------
// mst_div
// Impact time q = ((bmag - root) << 16) / a, saturated to 32 bits.
// Overflow check up front, then restoring division one bit per stage.
// ----------------------------------------------------------------------------
module mst_div #(
	parameter int MW = 47
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  mst_pkg::tag_t               tag_i,
	input  logic [MW-1:0]               a_i,
	input  logic [MW-1:0]               bmag_i,
	input  logic [MW-1:0]               root_i,
	output mst_pkg::tag_t               tag_o,
	output logic [mst_pkg::TIME_W-1:0]  q_o
);
	import mst_pkg::*;

	localparam int QW = TIME_W;
	localparam int WW = MW + QW;

	tag_t          tag_s  [0:QW];
	logic [MW:0]   rem_s  [0:QW];
	logic [QW-1:0] nlo_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [MW-1:0] a_s    [0:QW];
	logic          sat_s  [0:QW];

	logic [MW-1:0] num;
	logic          sat;

	assign num = bmag_i - root_i;
	assign sat = (a_i == '0) || ((WW'(num) << TIME_FRAC) >= (WW'(a_i) << QW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s[0] <= '0;
		else if (en)
			tag_s[0] <= tag_i;
	end

	// dividend is num << 16; its bits above QW seed the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (MW+1)'(num >> TIME_FRAC);
			nlo_s[0] <= QW'({num[TIME_FRAC-1:0], {TIME_FRAC{1'b0}}});
			quo_s[0] <= '0;
			a_s[0]   <= a_i;
			sat_s[0] <= sat;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_stage
		logic [MW:0] rem2;
		logic        ge;

		assign rem2 = {rem_s[j-1][MW-1:0], nlo_s[j-1][QW-1]};
		assign ge   = rem2 >= {1'b0, a_s[j-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				tag_s[j] <= '0;
			else if (en)
				tag_s[j] <= tag_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? rem2 - {1'b0, a_s[j-1]} : rem2;
				nlo_s[j] <= nlo_s[j-1] << 1;
				quo_s[j] <= {quo_s[j-1][QW-2:0], ge};
				a_s[j]   <= a_s[j-1];
				sat_s[j] <= sat_s[j-1];
			end
		end
	end

	assign tag_o = tag_s[QW];
	assign q_o   = sat_s[QW] ? '1 : quo_s[QW];

endmodule

@@ src/moving_sphere_impact_time.sv @@
// ----------------------------------------------------------------------------
// moving_sphere_impact_time
// Time of first contact between two moving spheres, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | valid     | stall     | payload           | dir
//  ---------+-----------+-----------+-------------------+-----
//  request  | req_valid | req_stall | req  (req_t)      | in
//  response | rsp_valid | rsp_stall | rsp  (rsp_t)      | out
//  config   | cfg_we    | -         | cfg_wdata (32 b)  | in
//
// One transaction per cycle while req_stall is low. The path runs through
// four front stages, three discriminant stages, MW square root stages
// (one root bit each), 33 divider stages and the output register.
// Reset clears all valid bits and sets min_speed_sq to 1.
// A two-entry output register/skid takes results while rsp_stall is high;
// the pipeline freezes only once the skid entry is occupied.
// ----------------------------------------------------------------------------
module moving_sphere_impact_time #(
	parameter int COORD_WIDTH = 21,
	parameter int FRAC_BITS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  mst_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output mst_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [mst_pkg::SPEED_W-1:0]   cfg_wdata
);
	import mst_pkg::*;

	localparam int DW  = 2 * (COORD_WIDTH + 1) + 2;
	localparam int RRW = 2 * (RAD_W + 1);
	localparam int MW  = ((DW > RRW) ? DW : RRW) + 1;

	logic [SPEED_W-1:0] msq_q;
	logic               en;

	tag_t               tag_f, tag_d, tag_r, tag_q;
	logic [MW-1:0]      a_f, bmag_f, c_f, a_d, bmag_d, a_r, bmag_r, root_r;
	logic [2*MW-1:0]    d_d;
	logic [TIME_W-1:0]  q_t;

	rsp_t               res;
	rsp_t               out_q, skid_q;
	logic               out_valid_q, skid_valid_q, out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			msq_q <= SPEED_W'(1);
		else if (cfg_we)
			msq_q <= cfg_wdata;
	end

	assign en = !skid_valid_q;

	mst_front #(
		.CW (COORD_WIDTH),
		.FB (FRAC_BITS),
		.MW (MW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (req_valid),
		.req_i   (req),
		.msq_i   (msq_q),
		.tag_o   (tag_f),
		.a_o     (a_f),
		.bmag_o  (bmag_f),
		.c_o     (c_f)
	);

	mst_disc #(.MW(MW)) u_disc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (tag_f),
		.a_i    (a_f),
		.bmag_i (bmag_f),
		.c_i    (c_f),
		.tag_o  (tag_d),
		.d_o    (d_d),
		.a_o    (a_d),
		.bmag_o (bmag_d)
	);

	mst_sqrt #(.MW(MW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (tag_d),
		.d_i    (d_d),
		.a_i    (a_d),
		.bmag_i (bmag_d),
		.tag_o  (tag_r),
		.root_o (root_r),
		.a_o    (a_r),
		.bmag_o (bmag_r)
	);

	mst_div #(.MW(MW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (tag_r),
		.a_i    (a_r),
		.bmag_i (bmag_r),
		.root_i (root_r),
		.tag_o  (tag_q),
		.q_o    (q_t)
	);

	always_comb begin
		res.contact_class = tag_q.cls;
		res.impact_time   = (tag_q.cls == CLS_HIT) ? q_t : '0;
	end

	assign out_take = out_valid_q && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take)
				skid_valid_q <= 1'b0;
		end else if (tag_q.valid) begin
			if (out_valid_q && rsp_stall)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take)
				out_q <= skid_q;
		end else if (tag_q.valid) begin
			if (out_valid_q && rsp_stall)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	assign req_stall = skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output transaction");

	a_time_zero_unless_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.contact_class != CLS_HIT) |-> (rsp.impact_time == '0))
		else $error("nonzero impact time on a non-hit result");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && rsp_stall))
		else $error("skid filled while output was free");

endmodule
